// File: rtl/cste_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cste_pkg
// Shared types for the step tone extractor: input byte item and tone record.
// ----------------------------------------------------------------------------
package cste_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IQ_W    = 12;
    localparam int unsigned QUAL_W  = 4;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned PCT_W   = 24;

    localparam logic [BYTE_W-1:0] TONE_MODE     = 8'd2;
    localparam logic [BYTE_W-1:0] TONE_MIN_DATA = 8'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              blob_start;
        logic              subevent_start;
        logic [BYTE_W-1:0] blob_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]      tone_channel;
        logic signed [IQ_W-1:0] tone_inphase;
        logic signed [IQ_W-1:0] tone_quadrature;
        logic [QUAL_W-1:0]      tone_quality;
        logic [SLOT_W-1:0]      tone_slot;
    } t_tone;

endpackage
`default_nettype wire

// File: rtl/cste_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cste_parser
// Step header parser and tone capture; one byte per transfer.
// ----------------------------------------------------------------------------
module cste_parser #(
    parameter int unsigned MAX_TONES = 72
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire cste_pkg::t_in_item i_item,
    output logic                  o_tone_valid,
    output cste_pkg::t_tone       o_tone
);

    localparam logic [1:0] PH_MODE = 2'd0;
    localparam logic [1:0] PH_CHAN = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(5);
    localparam logic [cste_pkg::SLOT_W-1:0] TONE_CAP = cste_pkg::SLOT_W'(MAX_TONES);

    logic [1:0]                      r_phase, n_phase;
    logic [cste_pkg::BYTE_W-1:0]     r_off, n_off;
    logic                            r_mode2, n_mode2;
    logic [cste_pkg::BYTE_W-1:0]     r_channel, n_channel;
    logic [cste_pkg::BYTE_W-1:0]     r_remain, n_remain;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic                            r_cap, n_cap;
    logic                            r_aband, n_aband;
    logic [cste_pkg::PCT_W-1:0]      r_pct, n_pct;
    logic [cste_pkg::SLOT_W-1:0]     r_count, n_count;

    logic [1:0]                      eff_phase;
    logic [cste_pkg::BYTE_W-1:0]     eff_off;
    logic                            eff_cap;
    logic                            eff_aband;
    logic [cste_pkg::SLOT_W-1:0]     eff_count;
    logic [cste_pkg::BYTE_W-1:0]     b;
    logic [cste_pkg::BYTE_W-1:0]     len;
    logic [cste_pkg::BYTE_W-1:0]     rem_dec;
    logic                            emit;

    always_comb begin
        b         = i_item.data_byte;
        len       = i_item.blob_length;
        eff_phase = i_item.blob_start ? PH_MODE : r_phase;
        eff_off   = i_item.blob_start ? '0 : r_off;
        eff_cap   = i_item.blob_start ? 1'b0 : r_cap;
        eff_aband = i_item.blob_start ? 1'b0 : r_aband;
        eff_count = (i_item.blob_start && i_item.subevent_start) ? '0 : r_count;
        rem_dec   = (r_remain != '0) ? r_remain - 8'd1 : '0;

        n_phase   = eff_phase;
        n_off     = eff_off;
        n_mode2   = r_mode2;
        n_channel = r_channel;
        n_remain  = r_remain;
        n_pos     = r_pos;
        n_cap     = eff_cap;
        n_aband   = eff_aband;
        n_pct     = r_pct;
        n_count   = eff_count;
        emit      = 1'b0;

        if (!eff_aband) begin
            unique case (eff_phase)
                PH_MODE: begin
                    if ({1'b0, eff_off} + 9'd3 > {1'b0, len}) begin
                        n_aband = 1'b1;
                    end else begin
                        n_mode2 = (b == cste_pkg::TONE_MODE);
                        n_phase = PH_CHAN;
                    end
                end
                PH_CHAN: begin
                    n_channel = b;
                    n_phase   = PH_LEN;
                end
                PH_LEN: begin
                    if ({2'b0, eff_off} + 10'd1 + {2'b0, b} > {2'b0, len}) begin
                        n_aband = 1'b1;
                    end else begin
                        n_remain = b;
                        n_pos    = '0;
                        n_pct    = '0;
                        n_cap    = r_mode2 && (b >= cste_pkg::TONE_MIN_DATA);
                        n_phase  = (b != '0) ? PH_DATA : PH_MODE;
                    end
                end
                PH_DATA: begin
                    if (eff_cap) begin
                        case (r_pos)
                            POS_W'(1): n_pct[7:0]   = b;
                            POS_W'(2): n_pct[15:8]  = b;
                            POS_W'(3): n_pct[23:16] = b;
                            POS_W'(4): begin
                                if (eff_count < TONE_CAP) begin
                                    emit    = 1'b1;
                                    n_count = eff_count + 7'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (r_pos < POS_SAT) begin
                        n_pos = r_pos + 3'd1;
                    end
                    n_remain = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_MODE;
                    end
                end
                default: ;
            endcase
            if (!n_aband && eff_off != 8'hff) begin
                n_off = eff_off + 8'd1;
            end
        end
    end

    always_comb begin
        o_tone_valid           = i_fire && emit;
        o_tone.tone_channel    = r_channel;
        o_tone.tone_inphase    = $signed(r_pct[11:0]);
        o_tone.tone_quadrature = $signed(r_pct[23:12]);
        o_tone.tone_quality    = b[3:0];
        o_tone.tone_slot       = eff_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MODE;
            r_off     <= '0;
            r_mode2   <= 1'b0;
            r_channel <= '0;
            r_remain  <= '0;
            r_pos     <= '0;
            r_cap     <= 1'b0;
            r_aband   <= 1'b0;
            r_pct     <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_mode2   <= n_mode2;
            r_channel <= n_channel;
            r_remain  <= n_remain;
            r_pos     <= n_pos;
            r_cap     <= n_cap;
            r_aband   <= n_aband;
            r_pct     <= n_pct;
            r_count   <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: rtl/cste_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cste_out_buf
// Result register with skid stage for tone records.
// ----------------------------------------------------------------------------
module cste_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cste_pkg::t_tone i_tone,
    output logic                 o_space,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output cste_pkg::t_tone      o_out_item
);

    logic            r_main_v, r_skid_v;
    cste_pkg::t_tone r_main, r_skid;
    logic            pop;
    logic            main_v_after;

    assign pop          = r_main_v && i_out_ready;
    assign main_v_after = pop ? r_skid_v : r_main_v;
    assign o_space      = !r_skid_v;
    assign o_out_valid  = r_main_v;
    assign o_out_item   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= main_v_after || i_push;
            r_skid_v <= (r_skid_v && !pop) || (i_push && main_v_after);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !main_v_after) begin
            r_main <= i_tone;
        end else if (pop) begin
            r_main <= r_skid;
        end
        if (i_push && main_v_after) begin
            r_skid <= i_tone;
        end
    end

endmodule
`default_nettype wire

// File: rtl/cs_step_tone_extractor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_step_tone_extractor_core
// Channel-sounding step data parser that emits one record per captured tone.
// ----------------------------------------------------------------------------
// Takes one blob byte per cycle and keeps taking bytes while a tone record
// waits at the output: a result register plus a skid stage absorb one extra
// record, so input ready drops only when both hold a record. A tone is pushed
// on the transfer of data byte 4 (the fifth byte of data, counting from 0) of
// a mode-2 step and appears at the output the next cycle when the result
// register is free, later when it waits behind an earlier record; the header
// parse and tone capture are combinational logic.
// ----------------------------------------------------------------------------
module cs_step_tone_extractor_core #(
    parameter int unsigned MAX_TONES = 72
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cste_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cste_pkg::t_tone         o_out_item
);

    logic            fire;
    logic            tone_valid;
    cste_pkg::t_tone tone;
    logic            space;

    assign o_in_ready = space;
    assign fire       = i_in_valid && space;

    cste_parser #(
        .MAX_TONES(MAX_TONES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (i_in_item),
        .o_tone_valid (tone_valid),
        .o_tone       (tone)
    );

    cste_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tone_valid),
        .i_tone      (tone),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: rtl/cste_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cste_checker
// Port-level checks for the step tone extractor, bound to the top level.
// ----------------------------------------------------------------------------
module cste_checker #(
    parameter int unsigned MAX_TONES = 72
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire cste_pkg::t_tone o_out_item
);

    localparam logic [cste_pkg::SLOT_W-1:0] TONE_CAP = cste_pkg::SLOT_W'(MAX_TONES);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_slot_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.tone_slot < TONE_CAP))
        else $error("tone slot beyond cap");

endmodule

bind cs_step_tone_extractor_core cste_checker #(
    .MAX_TONES(MAX_TONES)
) u_cste_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire
